// ===== rtl/tlpq_pkg.sv =====
// ----------------------------------------------------------------------------
// tlpq_pkg
// Shared types and codes of the three-level priority queue: item structs,
// command and level codes, status codes and the result buffer size.
// ----------------------------------------------------------------------------
`default_nettype none

package tlpq_pkg;

  // field widths fixed by the item format
  localparam int unsigned TASK_ID_W = 16;
  localparam int unsigned LEVEL_W   = 2;
  localparam int unsigned TOTAL_W   = 6;

  // number of priority levels
  localparam int unsigned NUM_LEVELS = 3;

  // result buffer between the pipeline and the output channel
  localparam int unsigned BUF_DEPTH = 3;
  localparam int unsigned BUF_PTR_W = 2;

  // command codes
  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_POP    = 1'b1;

  // level codes
  localparam logic [LEVEL_W-1:0] LVL_WHENEVER  = 2'd0;
  localparam logic [LEVEL_W-1:0] LVL_IMPORTANT = 2'd1;
  localparam logic [LEVEL_W-1:0] LVL_URGENT    = 2'd2;

  // result status codes
  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  // one input item
  typedef struct packed {
    logic                 cmd;
    logic [LEVEL_W-1:0]   level;
    logic [TASK_ID_W-1:0] task_id;
  } in_item_t;

  // one result item
  typedef struct packed {
    status_e              status;
    logic [TASK_ID_W-1:0] popped_id;
    logic [LEVEL_W-1:0]   popped_level;
    logic [TOTAL_W-1:0]   total_count;
  } out_item_t;

  // decision of the control stage, carried alongside the memory read
  typedef struct packed {
    status_e            status;
    logic [LEVEL_W-1:0] popped_level;
    logic [TOTAL_W-1:0] total_count;
    logic               pop_hit;
  } meta_t;

endpackage

`default_nettype wire

// ===== rtl/three_level_priority_queue_core.sv =====
// ----------------------------------------------------------------------------
// three_level_priority_queue_core
// Priority queue of task identifiers over three levels, each level a
// bounded first-in first-out queue in one shared task memory.
// ----------------------------------------------------------------------------
//  channel  | handshake               | payload
//  ---------+-------------------------+---------------------------------------
//  input    | in_valid_i / in_stall_o | in_item_i  (cmd, level, task_id)
//  output   | out_valid_o/ out_stall_i| out_item_o (status, popped_id,
//           |                         |             popped_level, total_count)
//
//  one item is accepted per cycle while in_stall_o is low; its result is
//  offered after the registered read of the task memory and the write into
//  the result queue.
//  pointers and counts clear on reset; the task memory needs no clearing,
//  so items are taken right after reset.
//  a three-entry result queue absorbs output stalls; in_stall_o rises once
//  the results held in that queue plus the one in flight reach three.
// ----------------------------------------------------------------------------
`default_nettype none

module three_level_priority_queue_core #(
  parameter int unsigned DEPTH_PER_LEVEL = 16,
  parameter int unsigned ID_WIDTH        = 16
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire tlpq_pkg::in_item_t  in_item_i,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output tlpq_pkg::out_item_t      out_item_o
);

  import tlpq_pkg::*;

  localparam int unsigned RAM_DEPTH = NUM_LEVELS * DEPTH_PER_LEVEL;
  localparam int unsigned ADDR_W    = $clog2(RAM_DEPTH);

  logic                 accept;
  logic                 ram_we;
  logic [ADDR_W-1:0]    ram_waddr;
  logic [ID_WIDTH-1:0]  ram_wdata;
  logic                 ram_re;
  logic [ADDR_W-1:0]    ram_raddr;
  logic [ID_WIDTH-1:0]  ram_rdata;
  meta_t                meta;
  logic                 s1_valid_q;
  meta_t                s1_meta_q;
  out_item_t            result;
  logic [BUF_PTR_W-1:0] buf_count;

  // input handshake, space is counted over the stage in flight and the queue
  assign in_stall_o = !rst_ni ||
                      ((3'(buf_count) + 3'(s1_valid_q)) >= 3'(BUF_DEPTH));
  assign accept     = in_valid_i && !in_stall_o;

  tlpq_ctrl #(
    .DEPTH    (DEPTH_PER_LEVEL),
    .ID_WIDTH (ID_WIDTH),
    .ADDR_W   (ADDR_W)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .item_i      (in_item_i),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .ram_re_o    (ram_re),
    .ram_raddr_o (ram_raddr),
    .meta_o      (meta)
  );

  tlpq_ram #(
    .WIDTH (ID_WIDTH),
    .DEPTH (RAM_DEPTH)
  ) u_task_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // stage alongside the memory read
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_meta_q <= meta;
    end
  end

  // assemble the result item
  always_comb begin
    result.status       = s1_meta_q.status;
    result.popped_id    = s1_meta_q.pop_hit ? TASK_ID_W'(ram_rdata) : '0;
    result.popped_level = s1_meta_q.popped_level;
    result.total_count  = s1_meta_q.total_count;
  end

  tlpq_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (s1_valid_q),
    .push_item_i (result),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_item_o  (out_item_o),
    .count_o     (buf_count)
  );

endmodule

`default_nettype wire

// ===== rtl/tlpq_ram.sv =====
// ----------------------------------------------------------------------------
// tlpq_ram
// Generic single-write, single-read memory with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module tlpq_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 48
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port, holds while no read is issued
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== rtl/tlpq_ctrl.sv =====
// ----------------------------------------------------------------------------
// tlpq_ctrl
// Per-level pointers and counts: decides insert or pop, drives the task
// memory and produces the status, level and total of each item.
// ----------------------------------------------------------------------------
`default_nettype none

module tlpq_ctrl #(
  parameter int unsigned DEPTH    = 16,
  parameter int unsigned ID_WIDTH = 16,
  parameter int unsigned ADDR_W   = 6
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  accept_i,
  input  wire tlpq_pkg::in_item_t    item_i,
  output logic                       ram_we_o,
  output logic [ADDR_W-1:0]          ram_waddr_o,
  output logic [ID_WIDTH-1:0]        ram_wdata_o,
  output logic                       ram_re_o,
  output logic [ADDR_W-1:0]          ram_raddr_o,
  output tlpq_pkg::meta_t            meta_o
);

  import tlpq_pkg::*;

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam int unsigned TOT_W = $clog2(NUM_LEVELS * DEPTH + 1);

  logic [PTR_W-1:0] rd_ptr_q [NUM_LEVELS];
  logic [PTR_W-1:0] rd_ptr_d [NUM_LEVELS];
  logic [PTR_W-1:0] wr_ptr_q [NUM_LEVELS];
  logic [PTR_W-1:0] wr_ptr_d [NUM_LEVELS];
  logic [CNT_W-1:0] cnt_q    [NUM_LEVELS];
  logic [CNT_W-1:0] cnt_d    [NUM_LEVELS];
  logic [TOT_W-1:0] total_q;
  logic [TOT_W-1:0] total_d;

  logic [LEVEL_W-1:0] ins_lvl;
  logic [LEVEL_W-1:0] pop_lvl;
  logic               ins_full;
  logic               any_held;
  logic               is_pop;
  logic               ins_ok;
  logic               pop_hit;
  logic               pop_ok;

  // first entry of a level in the shared memory
  function automatic logic [ADDR_W-1:0] level_base(input logic [LEVEL_W-1:0] lvl);
    logic [ADDR_W-1:0] base;
    unique case (lvl)
      LVL_URGENT:    base = ADDR_W'(2 * DEPTH);
      LVL_IMPORTANT: base = ADDR_W'(DEPTH);
      default:       base = '0;
    endcase
    return base;
  endfunction

  // pointer advance with wrap at the level depth
  function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  // insert target, level three counts as urgent
  always_comb begin
    ins_lvl  = (item_i.level > LVL_URGENT) ? LVL_URGENT : item_i.level;
    ins_full = (cnt_q[ins_lvl] == CNT_W'(DEPTH));
  end

  // highest non-empty level for a pop
  always_comb begin
    any_held = 1'b1;
    if (cnt_q[LVL_URGENT] != '0) begin
      pop_lvl = LVL_URGENT;
    end else if (cnt_q[LVL_IMPORTANT] != '0) begin
      pop_lvl = LVL_IMPORTANT;
    end else if (cnt_q[LVL_WHENEVER] != '0) begin
      pop_lvl = LVL_WHENEVER;
    end else begin
      pop_lvl  = LVL_WHENEVER;
      any_held = 1'b0;
    end
  end

  assign is_pop  = (item_i.cmd == CMD_POP);
  assign pop_hit = is_pop && any_held;
  assign ins_ok  = accept_i && !is_pop && !ins_full;
  assign pop_ok  = accept_i && pop_hit;

  // memory requests
  assign ram_we_o    = ins_ok;
  assign ram_waddr_o = level_base(ins_lvl) + ADDR_W'(wr_ptr_q[ins_lvl]);
  assign ram_wdata_o = ID_WIDTH'(item_i.task_id);
  assign ram_re_o    = pop_ok;
  assign ram_raddr_o = level_base(pop_lvl) + ADDR_W'(rd_ptr_q[pop_lvl]);

  // next pointers and counts
  always_comb begin
    rd_ptr_d = rd_ptr_q;
    wr_ptr_d = wr_ptr_q;
    cnt_d    = cnt_q;
    total_d  = total_q;
    if (ins_ok) begin
      wr_ptr_d[ins_lvl] = next_slot(wr_ptr_q[ins_lvl]);
      cnt_d[ins_lvl]    = cnt_q[ins_lvl] + 1'b1;
      total_d           = total_q + 1'b1;
    end
    if (pop_ok) begin
      rd_ptr_d[pop_lvl] = next_slot(rd_ptr_q[pop_lvl]);
      cnt_d[pop_lvl]    = cnt_q[pop_lvl] - 1'b1;
      total_d           = total_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_LEVELS; i++) begin
        rd_ptr_q[i] <= '0;
        wr_ptr_q[i] <= '0;
        cnt_q[i]    <= '0;
      end
      total_q <= '0;
    end else begin
      rd_ptr_q <= rd_ptr_d;
      wr_ptr_q <= wr_ptr_d;
      cnt_q    <= cnt_d;
      total_q  <= total_d;
    end
  end

  // item decision
  always_comb begin
    if (is_pop) begin
      meta_o.status = any_held ? ST_DONE : ST_EMPTY;
    end else begin
      meta_o.status = ins_full ? ST_FULL : ST_DONE;
    end
    meta_o.popped_level = pop_hit ? pop_lvl : LVL_WHENEVER;
    meta_o.total_count  = TOTAL_W'(total_d);
    meta_o.pop_hit      = pop_hit;
  end

endmodule

`default_nettype wire

// ===== rtl/tlpq_out_buf.sv =====
// ----------------------------------------------------------------------------
// tlpq_out_buf
// Small result queue that decouples the pipeline from the output channel
// so that items keep flowing while the receiver stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module tlpq_out_buf (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  push_i,
  input  wire tlpq_pkg::out_item_t   push_item_i,
  input  wire logic                  out_stall_i,
  output logic                       out_valid_o,
  output tlpq_pkg::out_item_t        out_item_o,
  output logic [tlpq_pkg::BUF_PTR_W-1:0] count_o
);

  import tlpq_pkg::*;

  out_item_t            slot_q [BUF_DEPTH];
  logic [BUF_PTR_W-1:0] rd_ptr_q;
  logic [BUF_PTR_W-1:0] rd_ptr_d;
  logic [BUF_PTR_W-1:0] wr_ptr_q;
  logic [BUF_PTR_W-1:0] wr_ptr_d;
  logic [BUF_PTR_W-1:0] count_q;
  logic [BUF_PTR_W-1:0] count_d;
  logic                 pop;

  function automatic logic [BUF_PTR_W-1:0] bump(input logic [BUF_PTR_W-1:0] p);
    return (p == BUF_PTR_W'(BUF_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign out_valid_o = (count_q != '0);
  assign out_item_o  = slot_q[rd_ptr_q];
  assign count_o     = count_q;
  assign pop         = out_valid_o && !out_stall_i;

  // pointer and fill bookkeeping
  always_comb begin
    rd_ptr_d = pop    ? bump(rd_ptr_q) : rd_ptr_q;
    wr_ptr_d = push_i ? bump(wr_ptr_q) : wr_ptr_q;
    case ({push_i, pop})
      2'b10:   count_d = count_q + 1'b1;
      2'b01:   count_d = count_q - 1'b1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_ptr_q <= '0;
      wr_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      rd_ptr_q <= rd_ptr_d;
      wr_ptr_q <= wr_ptr_d;
      count_q  <= count_d;
    end
  end

  // result storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/tlpq_checker.sv =====
// ----------------------------------------------------------------------------
// tlpq_checker
// Port-level checks of the priority queue core, attached by a bind.
// ----------------------------------------------------------------------------
`default_nettype none

module tlpq_checker (
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                in_valid_i,
  input wire logic                in_stall_o,
  input wire tlpq_pkg::in_item_t  in_item_i,
  input wire logic                out_valid_o,
  input wire logic                out_stall_i,
  input wire tlpq_pkg::out_item_t out_item_o
);

  import tlpq_pkg::*;

  logic in_acc;

  assign in_acc = in_valid_i && !in_stall_o;

  // every accepted item is followed by a result on the output
  a_result_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |-> ##2 out_valid_o)
    else $error("accepted item without result two cycles later");

  // a result only shows up after an item went in
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && !in_stall_o, 2))
    else $error("result appeared with no accepted item");

  // a pop on an empty queue leaves nothing held and pops nothing
  a_empty_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_item_o.status == ST_EMPTY) |->
      (out_item_o.total_count == '0 && out_item_o.popped_id == '0 &&
       out_item_o.popped_level == LVL_WHENEVER))
    else $error("empty pop reports held or popped tasks");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(out_item_o)))
    else $error("stalled result changed");

endmodule

bind three_level_priority_queue_core tlpq_checker u_checker (.*);

`default_nettype wire
